>>> rtl/tap_hold_gesture_detector_defines.svh
// Assertion macros shared by the tap and hold gesture detector.
`ifndef TAP_HOLD_GESTURE_DETECTOR_DEFINES_SVH
`define TAP_HOLD_GESTURE_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define THGD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define THGD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/thgd_pkg.sv
// Package of types and constants for the tap and hold gesture detector.
package thgd_pkg;

  // Default widths of the timestamp and the touch coordinate.
  localparam int unsigned TimeBitsDef  = 32;
  localparam int unsigned CoordBitsDef = 12;

  // Configuration port shape.
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 16;
  localparam int unsigned HeaderBits  = 12;
  localparam int unsigned WindowBits  = 16;

  // Register reset values.
  localparam logic [HeaderBits-1:0] HeaderHeightRst = 12'd40;
  localparam logic [WindowBits-1:0] DoubleWindowRst = 16'd400;
  localparam logic [WindowBits-1:0] HoldMsRst       = 16'd2000;

  // Configuration register indexes.
  typedef enum logic [CfgIdxBits-1:0] {
    CFG_ENABLED        = 3'd0,
    CFG_HEADER_HEIGHT  = 3'd1,
    CFG_DOUBLE_WINDOW  = 3'd2,
    CFG_HOLD_MS        = 3'd3,
    CFG_BUTTON_PRESENT = 3'd4
  } cfg_idx_e;

  // Gesture codes of a result.
  typedef enum logic [1:0] {
    GEST_NONE  = 2'd0,
    GEST_SLEEP = 2'd1,
    GEST_DIAG  = 2'd2
  } gesture_e;

  // Per-tick control handed to the touch and button units.
  typedef struct packed {
    logic step;
    logic asleep;
    logic modal;
  } thgd_ctl_t;

endpackage

>>> rtl/thgd_touch.sv
// Touch unit: edge detection, double tap in the header band and header hold.
module thgd_touch
  import thgd_pkg::*;
#(
  parameter int unsigned TIME_BITS  = TimeBitsDef,
  parameter int unsigned COORD_BITS = CoordBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  thgd_ctl_t             ctl_i,
  input  logic                  touch_down_i,
  input  logic [COORD_BITS-1:0] touch_y_i,
  input  logic [TIME_BITS-1:0]  now_ms_i,
  input  logic [HeaderBits-1:0] header_height_i,
  input  logic [WindowBits-1:0] double_window_ms_i,
  input  logic [WindowBits-1:0] hold_ms_i,
  output gesture_e              gesture_o
);

  logic                 prev_q, prev_d;
  logic                 armed_q, armed_d;
  logic                 in_header_q, in_header_d;
  logic [TIME_BITS-1:0] press_q, press_d;
  logic [TIME_BITS-1:0] last_rise_q, last_rise_d;

  logic                 rise, fall, in_band, dbl;
  logic [TIME_BITS-1:0] rise_gap, hold_gap, press_ref;
  gesture_e             gesture;

  // Edges and the comparisons of this tick.
  assign rise      = touch_down_i & ~prev_q;
  assign fall      = ~touch_down_i & prev_q;
  assign in_band   = (32'(touch_y_i) < 32'(header_height_i));
  assign rise_gap  = now_ms_i - last_rise_q;
  assign dbl       = (last_rise_q != '0) && (rise_gap <= TIME_BITS'(double_window_ms_i));
  assign press_ref = rise ? now_ms_i : press_q;
  assign hold_gap  = now_ms_i - press_ref;

  // Next state and gesture for one tick.
  always_comb begin
    prev_d      = touch_down_i;
    armed_d     = armed_q;
    in_header_d = in_header_q;
    press_d     = press_q;
    last_rise_d = last_rise_q;
    gesture     = GEST_NONE;
    if (ctl_i.asleep) begin
      // A touch wakes the display and forgets any earlier rise.
      if (rise) begin
        armed_d     = 1'b0;
        last_rise_d = '0;
        gesture     = GEST_SLEEP;
      end
    end else if (rise && in_band && dbl) begin
      // Second header rise inside the window.
      in_header_d = 1'b1;
      press_d     = now_ms_i;
      armed_d     = 1'b0;
      last_rise_d = '0;
      gesture     = GEST_SLEEP;
    end else begin
      if (rise) begin
        in_header_d = in_band;
        press_d     = now_ms_i;
        armed_d     = in_band;
        if (in_band) begin
          last_rise_d = now_ms_i;
        end
      end
      if (fall) begin
        armed_d     = 1'b0;
        in_header_d = 1'b0;
      end
      if (ctl_i.modal) begin
        armed_d = 1'b0;
      end else if (touch_down_i && armed_d && in_header_d &&
                   (hold_gap >= TIME_BITS'(hold_ms_i))) begin
        armed_d = 1'b0;
        gesture = GEST_DIAG;
      end
    end
  end

  assign gesture_o = gesture;

  // State advances only on a processed tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= 1'b0;
      armed_q     <= 1'b0;
      in_header_q <= 1'b0;
      press_q     <= '0;
      last_rise_q <= '0;
    end else if (ctl_i.step) begin
      prev_q      <= prev_d;
      armed_q     <= armed_d;
      in_header_q <= in_header_d;
      press_q     <= press_d;
      last_rise_q <= last_rise_d;
    end
  end

endmodule

>>> rtl/thgd_button.sv
// Button unit: long press detection on the push button.
module thgd_button
  import thgd_pkg::*;
#(
  parameter int unsigned TIME_BITS = TimeBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  thgd_ctl_t             ctl_i,
  input  logic                  button_down_i,
  input  logic [TIME_BITS-1:0]  now_ms_i,
  input  logic [WindowBits-1:0] hold_ms_i,
  output gesture_e              gesture_o
);

  logic                 prev_q;
  logic                 armed_q, armed_d;
  logic [TIME_BITS-1:0] press_q, press_d;
  logic                 rise;
  logic [TIME_BITS-1:0] hold_gap;
  gesture_e             gesture;

  assign rise     = button_down_i & ~prev_q;
  assign press_d  = rise ? now_ms_i : press_q;
  assign hold_gap = now_ms_i - press_d;

  // Arm on a press; disarm on release, sleep, a modal screen or when the hold fires.
  always_comb begin
    armed_d = armed_q | rise;
    gesture = GEST_NONE;
    if (!button_down_i || ctl_i.asleep || ctl_i.modal) begin
      armed_d = 1'b0;
    end else if (armed_d && (hold_gap >= TIME_BITS'(hold_ms_i))) begin
      armed_d = 1'b0;
      gesture = GEST_DIAG;
    end
  end

  assign gesture_o = gesture;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= 1'b0;
      armed_q <= 1'b0;
      press_q <= '0;
    end else if (ctl_i.step) begin
      prev_q  <= button_down_i;
      armed_q <= armed_d;
      press_q <= press_d;
    end
  end

endmodule

>>> rtl/tap_hold_gesture_detector.sv
// Top level of the tap and hold gesture detector.
//
//  Channel  Direction  Handshake                  Payload
//  in       request    in_valid_i / in_stall_o    touch, button, time, sleep, modal
//  out      result     out_valid_o / out_stall_i  gesture_o
//  cfg      write      cfg_we_i                   cfg_index_i, cfg_data_i
//
// A request is registered in the input register on entry; its gesture is computed
// and registered in the result register when the request advances, which a stall
// on the result side can hold off. One request can be accepted every cycle while the
// result side does not stall. The single evaluation stage lies between the input
// register and the result register. Reset clears the gesture state and loads
// the register defaults. A stall on the result side holds the result and then the input register.
module tap_hold_gesture_detector
  import thgd_pkg::*;
#(
  parameter int unsigned TIME_BITS  = TimeBitsDef,
  parameter int unsigned COORD_BITS = CoordBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   touch_down_i,
  input  logic [COORD_BITS-1:0]  touch_y_i,
  input  logic                   button_down_i,
  input  logic [TIME_BITS-1:0]   now_ms_i,
  input  logic                   asleep_i,
  input  logic                   modal_blocks_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             gesture_o,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_index_i,
  input  logic [CfgDataBits-1:0] cfg_data_i
);

`include "tap_hold_gesture_detector_defines.svh"

  // Configuration registers.
  logic                  enabled_q;
  logic [HeaderBits-1:0] header_height_q;
  logic [WindowBits-1:0] double_window_q;
  logic [WindowBits-1:0] hold_ms_q;
  logic                  button_present_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q        <= 1'b0;
      header_height_q  <= HeaderHeightRst;
      double_window_q  <= DoubleWindowRst;
      hold_ms_q        <= HoldMsRst;
      button_present_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ENABLED:        enabled_q        <= cfg_data_i[0];
        CFG_HEADER_HEIGHT:  header_height_q  <= cfg_data_i[HeaderBits-1:0];
        CFG_DOUBLE_WINDOW:  double_window_q  <= cfg_data_i[WindowBits-1:0];
        CFG_HOLD_MS:        hold_ms_q        <= cfg_data_i[WindowBits-1:0];
        CFG_BUTTON_PRESENT: button_present_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Input register and pipeline control.
  logic                  in_valid_q;
  logic                  touch_down_q;
  logic [COORD_BITS-1:0] touch_y_q;
  logic                  button_down_q;
  logic [TIME_BITS-1:0]  now_ms_q;
  logic                  asleep_q;
  logic                  modal_q;
  logic                  out_valid_q;
  gesture_e              gesture_q, gesture_d;
  logic                  advance, accept;

  assign advance    = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & ~advance;
  assign accept     = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      touch_down_q  <= touch_down_i;
      touch_y_q     <= touch_y_i;
      button_down_q <= button_down_i;
      now_ms_q      <= now_ms_i;
      asleep_q      <= asleep_i;
      modal_q       <= modal_blocks_i;
    end
  end

  // Evaluation of one request by the touch and button units.
  thgd_ctl_t touch_ctl, button_ctl;
  gesture_e  touch_gest, button_gest;

  assign touch_ctl.step    = advance & enabled_q;
  assign touch_ctl.asleep  = asleep_q;
  assign touch_ctl.modal   = modal_q;
  // The button is left untouched on a tick where touch toggled sleep.
  assign button_ctl.step   = advance & enabled_q & button_present_q &
                             (touch_gest != GEST_SLEEP);
  assign button_ctl.asleep = asleep_q;
  assign button_ctl.modal  = modal_q;

  thgd_touch #(
    .TIME_BITS  (TIME_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_touch (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .ctl_i              (touch_ctl),
    .touch_down_i       (touch_down_q),
    .touch_y_i          (touch_y_q),
    .now_ms_i           (now_ms_q),
    .header_height_i    (header_height_q),
    .double_window_ms_i (double_window_q),
    .hold_ms_i          (hold_ms_q),
    .gesture_o          (touch_gest)
  );

  thgd_button #(
    .TIME_BITS (TIME_BITS)
  ) u_button (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (button_ctl),
    .button_down_i (button_down_q),
    .now_ms_i      (now_ms_q),
    .hold_ms_i     (hold_ms_q),
    .gesture_o     (button_gest)
  );

  // Combine the two sources, touch sleep toggle first.
  always_comb begin
    gesture_d = GEST_NONE;
    if (enabled_q) begin
      if (touch_gest == GEST_SLEEP) begin
        gesture_d = GEST_SLEEP;
      end else if ((touch_gest == GEST_DIAG) ||
                   (button_present_q && (button_gest == GEST_DIAG))) begin
        gesture_d = GEST_DIAG;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      gesture_q <= gesture_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign gesture_o   = gesture_q;

  // Checks on the evaluation stage.
  `THGD_ASSERT_NEXT(a_disabled_none, clk_i, rst_ni, advance && !enabled_q,
    gesture_q == GEST_NONE, "disabled block produced a gesture")
  `THGD_ASSERT_NEXT(a_no_diag_blocked, clk_i, rst_ni, advance && (asleep_q || modal_q),
    gesture_q != GEST_DIAG, "diagnostics while asleep or under a modal screen")
  `THGD_ASSERT_NEXT(a_held_request_kept, clk_i, rst_ni, in_valid_q && !advance,
    in_valid_q, "held request dropped from the input register")
  `THGD_ASSERT_NOW(a_stall_only_when_full, clk_i, rst_ni, in_stall_o,
    in_valid_q && out_valid_q && out_stall_i, "input stalled with room downstream")

endmodule

>>> tb/thgd_gesture_checker.sv
// Checker for the tap and hold gesture detector: predicts each gesture and compares it.
module thgd_gesture_checker
  import thgd_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic                    touch_down_i,
  input  logic [CoordBitsDef-1:0] touch_y_i,
  input  logic                    button_down_i,
  input  logic [TimeBitsDef-1:0]  now_ms_i,
  input  logic                    asleep_i,
  input  logic                    modal_blocks_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic [1:0]              gesture_i,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxBits-1:0]   cfg_index_i,
  input  logic [CfgDataBits-1:0]  cfg_data_i,
  output int unsigned             fail_count_o,
  output int unsigned             gestures_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the configuration registers.
  logic                   en_q;
  logic [HeaderBits-1:0]  header_q;
  logic [WindowBits-1:0]  window_q;
  logic [WindowBits-1:0]  hold_q;
  logic                   button_on_q;

  // Shadow copy of the gesture state.
  logic                   touch_prev;
  logic                   touch_armed;
  logic                   touch_in_header;
  logic [TimeBitsDef-1:0] touch_press_ms;
  logic [TimeBitsDef-1:0] touch_rise_ms;
  logic                   button_prev;
  logic                   button_armed;
  logic [TimeBitsDef-1:0] button_press_ms;

  // Gestures owed by the block, oldest first.
  gesture_e gesture_due[$];

  task automatic report_mismatch(input string what);
    fail_count_o++;
    $display("%0t ns: gesture check: %s", $realtime, what);
  endtask

  // Works out the gesture of one request and advances the shadow state.
  function automatic gesture_e predict_gesture(
    input logic                    down,
    input logic [CoordBitsDef-1:0] y,
    input logic                    btn,
    input logic [TimeBitsDef-1:0]  now,
    input logic                    sleeping,
    input logic                    modal
  );
    logic                   rise;
    logic                   fall;
    logic                   second_tap;
    logic [TimeBitsDef-1:0] gap_ms;
    gesture_e               touch_g;
    gesture_e               button_g;
    touch_g  = GEST_NONE;
    button_g = GEST_NONE;
    if (!en_q) return GEST_NONE;

    // Touch source. Differences wrap because they are taken at the timestamp width.
    rise       = down && !touch_prev;
    fall       = !down && touch_prev;
    touch_prev = down;
    if (sleeping) begin
      if (rise) begin
        touch_armed   = 1'b0;
        touch_rise_ms = '0;
        touch_g       = GEST_SLEEP;
      end
    end else begin
      if (rise) begin
        touch_in_header = (y < header_q);
        touch_press_ms  = now;
        touch_armed     = touch_in_header;
        if (touch_in_header) begin
          // A stored rise time of zero stands for no earlier rise.
          gap_ms        = now - touch_rise_ms;
          second_tap    = (touch_rise_ms != '0) && (gap_ms <= window_q);
          touch_rise_ms = now;
          if (second_tap) begin
            touch_rise_ms = '0;
            touch_armed   = 1'b0;
            touch_g       = GEST_SLEEP;
          end
        end
      end
      if (touch_g != GEST_SLEEP) begin
        if (fall) begin
          touch_armed     = 1'b0;
          touch_in_header = 1'b0;
        end
        gap_ms = now - touch_press_ms;
        if (modal) begin
          touch_armed = 1'b0;
        end else if (down && touch_armed && touch_in_header && gap_ms >= hold_q) begin
          touch_armed = 1'b0;
          touch_g     = GEST_DIAG;
        end
      end
    end

    // A sleep toggle from touch leaves the button state as it was.
    if (touch_g == GEST_SLEEP) return GEST_SLEEP;

    // Button source, only when it is present.
    if (button_on_q) begin
      rise        = btn && !button_prev;
      button_prev = btn;
      if (rise) begin
        button_press_ms = now;
        button_armed    = 1'b1;
      end
      gap_ms = now - button_press_ms;
      if (!btn || sleeping || modal) begin
        button_armed = 1'b0;
      end else if (button_armed && gap_ms >= hold_q) begin
        button_armed = 1'b0;
        button_g     = GEST_DIAG;
      end
    end
    return (touch_g == GEST_DIAG || button_g == GEST_DIAG) ? GEST_DIAG : GEST_NONE;
  endfunction

  // Watch the register port and both channels at every rising edge.
  always @(posedge clk_i) begin : watch
    gesture_e want;
    if (!rst_ni) begin
      en_q            = 1'b0;
      header_q        = HeaderHeightRst;
      window_q        = DoubleWindowRst;
      hold_q          = HoldMsRst;
      button_on_q     = 1'b0;
      touch_prev      = 1'b0;
      touch_armed     = 1'b0;
      touch_in_header = 1'b0;
      touch_press_ms  = '0;
      touch_rise_ms   = '0;
      button_prev     = 1'b0;
      button_armed    = 1'b0;
      button_press_ms = '0;
      gesture_due.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_ENABLED:        en_q        = cfg_data_i[0];
          CFG_HEADER_HEIGHT:  header_q    = cfg_data_i[HeaderBits-1:0];
          CFG_DOUBLE_WINDOW:  window_q    = cfg_data_i[WindowBits-1:0];
          CFG_HOLD_MS:        hold_q      = cfg_data_i[WindowBits-1:0];
          CFG_BUTTON_PRESENT: button_on_q = cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (gesture_due.size() == 0) begin
          report_mismatch($sformatf("gesture %0d with no request pending", gesture_i));
        end else begin
          want = gesture_due.pop_front();
          if (gesture_i !== want) begin
            report_mismatch($sformatf("gesture %0d, expected %0d (%s)",
                                      gesture_i, want, want.name()));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        gesture_due.push_back(predict_gesture(touch_down_i, touch_y_i, button_down_i,
                                              now_ms_i, asleep_i, modal_blocks_i));
      end
    end
    gestures_due_o = gesture_due.size();
  end

endmodule

>>> tb/testbench.sv
// Top of the gesture detector testbench: clock, reset, stimulus and verdict.
module testbench
  import thgd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DrainCycles    = 4;
  localparam int unsigned HoldoffCycles  = 64;
  localparam int unsigned WatchdogLimit  = 1000;
  localparam logic [CfgIdxBits-1:0] CFG_UNUSED_IDX = 3'd7;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic                    touch_down_i;
  logic [CoordBitsDef-1:0] touch_y_i;
  logic                    button_down_i;
  logic [TimeBitsDef-1:0]  now_ms_i;
  logic                    asleep_i;
  logic                    modal_blocks_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [1:0]              gesture_o;
  logic                    cfg_we_i;
  logic [CfgIdxBits-1:0]   cfg_index_i;
  logic [CfgDataBits-1:0]  cfg_data_i;

  int unsigned fail_count;
  int unsigned gestures_due;

  // Stimulus controls and the register values the stimulus is shaped for.
  bit                     idle_on;
  bit                     stall_on;
  int unsigned            holdoffs_asked;
  int unsigned            holdoffs_taken;
  int unsigned            requests_sent;
  logic [TimeBitsDef-1:0] stamp_ms;
  logic [HeaderBits-1:0]  header_now;
  logic [WindowBits-1:0]  window_now;
  logic [WindowBits-1:0]  hold_now;

  tap_hold_gesture_detector dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .touch_down_i   (touch_down_i),
    .touch_y_i      (touch_y_i),
    .button_down_i  (button_down_i),
    .now_ms_i       (now_ms_i),
    .asleep_i       (asleep_i),
    .modal_blocks_i (modal_blocks_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .gesture_o      (gesture_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  thgd_gesture_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .touch_down_i   (touch_down_i),
    .touch_y_i      (touch_y_i),
    .button_down_i  (button_down_i),
    .now_ms_i       (now_ms_i),
    .asleep_i       (asleep_i),
    .modal_blocks_i (modal_blocks_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .gesture_i      (gesture_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .fail_count_o   (fail_count),
    .gestures_due_o (gestures_due)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Result side: random stalls, and a long hold-off whenever one is asked for.
  initial begin
    int unsigned holdoff_left;
    holdoff_left = 0;
    out_stall_i  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holdoffs_taken != holdoffs_asked) begin
        holdoffs_taken = holdoffs_asked;
        holdoff_left   = HoldoffCycles;
      end
      if (holdoff_left != 0) begin
        holdoff_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= stall_on && ($urandom_range(99) < 15);
      end
    end
  end

  // Watchdog: ends the run when no handshake or register write happens for too long.
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Watchdog: no handshake for %0d cycles", quiet_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Offers one request, sometimes after a random idle gap, and waits until it is taken.
  task automatic send_tick(
    input logic                    down,
    input logic [CoordBitsDef-1:0] y,
    input logic                    btn,
    input logic [TimeBitsDef-1:0]  now,
    input logic                    sleeping,
    input logic                    modal
  );
    if (idle_on && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(2, 1)) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    touch_down_i   <= down;
    touch_y_i      <= y;
    button_down_i  <= btn;
    now_ms_i       <= now;
    asleep_i       <= sleeping;
    modal_blocks_i <= modal;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    requests_sent++;
  endtask

  // Stops offering and waits until every gesture owed has come out.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (gestures_due != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [CfgDataBits-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_HEADER_HEIGHT: header_now = data[HeaderBits-1:0];
      CFG_DOUBLE_WINDOW: window_now = data[WindowBits-1:0];
      CFG_HOLD_MS:       hold_now   = data[WindowBits-1:0];
      default: ;
    endcase
  endtask

  function automatic logic modal_roll();
    return $urandom_range(99) < 8;
  endfunction

  // Time advance between ticks of a press, sized so that holds are reached.
  function automatic int unsigned hold_stride();
    return $urandom_range(hold_now / 2 + 20, 0);
  endfunction

  // Time advance between taps, sized so that most pairs fall inside the window.
  function automatic int unsigned tap_stride();
    return $urandom_range(window_now / 2 + 5, 0);
  endfunction

  // Mostly header rows, with the band edge hit now and then.
  function automatic logic [CoordBitsDef-1:0] pick_y();
    int unsigned r;
    r = $urandom_range(9);
    if (header_now != 0 && r < 6) return CoordBitsDef'($urandom_range(header_now - 1, 0));
    if (r == 6) return header_now;
    if (header_now != 0 && r == 7) return header_now - 12'd1;
    return CoordBitsDef'($urandom_range(4095, 0));
  endfunction

  // One gesture-like sequence of requests with random content, or noise.
  task automatic play_sequence();
    int unsigned             kind;
    int unsigned             len;
    logic [CoordBitsDef-1:0] y;
    logic                    btn;
    logic                    sleeping;
    kind     = $urandom_range(9);
    len      = $urandom_range(6, 1);
    y        = pick_y();
    btn      = 1'($urandom_range(1));
    sleeping = ($urandom_range(9) == 0);
    case (kind)
      // Touch held for a while, sometimes with the button too.
      0, 1, 2: begin
        repeat (len) begin
          send_tick(1'b1, y, btn, stamp_ms, sleeping, modal_roll());
          stamp_ms += hold_stride();
        end
        send_tick(1'b0, y, 1'b0, stamp_ms, sleeping, 1'b0);
        stamp_ms += tap_stride();
      end
      // Two quick taps.
      3, 4: begin
        repeat (2) begin
          send_tick(1'b1, y, 1'b0, stamp_ms, sleeping, modal_roll());
          stamp_ms += tap_stride();
          send_tick(1'b0, y, 1'b0, stamp_ms, 1'b0, 1'b0);
          stamp_ms += tap_stride();
        end
      end
      // Button held for a while.
      5, 6: begin
        repeat (len) begin
          send_tick(1'b0, y, 1'b1, stamp_ms, sleeping, modal_roll());
          stamp_ms += hold_stride();
        end
        send_tick(1'b0, y, 1'b0, stamp_ms, 1'b0, 1'b0);
      end
      // Wake-up tap while asleep, button possibly held.
      7: begin
        send_tick(1'b1, y, btn, stamp_ms, 1'b1, modal_roll());
        stamp_ms += hold_stride();
        send_tick(1'b0, y, btn, stamp_ms, 1'b1, 1'b0);
      end
      // Noise on every field, time jumping anywhere now and then.
      default: begin
        repeat (len) begin
          if ($urandom_range(3) == 0) stamp_ms = $urandom();
          else stamp_ms += hold_stride();
          send_tick(1'($urandom_range(1)), CoordBitsDef'($urandom_range(4095, 0)),
                    1'($urandom_range(1)), stamp_ms, 1'($urandom_range(1)),
                    1'($urandom_range(1)));
        end
      end
    endcase
  endtask

  // One random phase under one register setting.
  task automatic run_phase(
    input logic [HeaderBits-1:0] hdr,
    input logic [WindowBits-1:0] win,
    input logic [WindowBits-1:0] hold,
    input logic                  btn_on,
    input int unsigned           n_ticks,
    input bit                    squeeze
  );
    int unsigned stop_at;
    bit          squeezed;
    squeezed = 1'b0;
    wait_idle();
    write_reg(CFG_HEADER_HEIGHT, CfgDataBits'(hdr));
    write_reg(CFG_DOUBLE_WINDOW, win);
    write_reg(CFG_HOLD_MS, hold);
    write_reg(CFG_BUTTON_PRESENT, CfgDataBits'(btn_on));
    // Start somewhere random, half the time just short of the wrap.
    stamp_ms = $urandom_range(1) ? $urandom() : ~TimeBitsDef'($urandom_range(200000, 0));
    stop_at  = requests_sent + n_ticks;
    while (requests_sent < stop_at) begin
      // Halfway through, the result side holds off while requests keep coming.
      if (squeeze && !squeezed && requests_sent + n_ticks / 2 >= stop_at) begin
        squeezed = 1'b1;
        holdoffs_asked++;
      end
      play_sequence();
    end
  endtask

  // Reset, directed requests, then random phases and the verdict.
  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    touch_down_i   = 1'b0;
    touch_y_i      = '0;
    button_down_i  = 1'b0;
    now_ms_i       = '0;
    asleep_i       = 1'b0;
    modal_blocks_i = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = CFG_ENABLED;
    cfg_data_i     = '0;
    idle_on        = 1'b1;
    stall_on       = 1'b1;
    holdoffs_asked = 0;
    holdoffs_taken = 0;
    requests_sent  = 0;
    stamp_ms       = '0;
    header_now     = HeaderHeightRst;
    window_now     = DoubleWindowRst;
    hold_now       = HoldMsRst;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Out of reset the block is disabled: a press leaves no trace.
    send_tick(1'b1, 12'd0, 1'b1, 32'd100, 1'b0, 1'b0);
    send_tick(1'b0, 12'd0, 1'b0, 32'd200, 1'b0, 1'b0);
    wait_idle();
    write_reg(CFG_ENABLED, 16'd1);
    write_reg(CFG_BUTTON_PRESENT, 16'd1);

    // A header rise at time zero cannot open a double tap.
    send_tick(1'b1, 12'd0, 1'b0, 32'd0, 1'b0, 1'b0);
    send_tick(1'b0, 12'd0, 1'b0, 32'd100, 1'b0, 1'b0);
    send_tick(1'b1, 12'd39, 1'b0, 32'd300, 1'b0, 1'b0);
    send_tick(1'b0, 12'd39, 1'b0, 32'd400, 1'b0, 1'b0);
    // Second rise exactly at the window edge with the button down: sleep toggle only.
    send_tick(1'b1, 12'd0, 1'b1, 32'd700, 1'b0, 1'b0);
    // The button is seen rising only now, then held past the hold time once.
    send_tick(1'b0, 12'd0, 1'b1, 32'd800, 1'b0, 1'b0);
    send_tick(1'b0, 12'd0, 1'b1, 32'd2800, 1'b0, 1'b0);
    send_tick(1'b0, 12'd0, 1'b1, 32'd9000, 1'b0, 1'b0);
    // Header touch held: does not fire just short of the hold time, then fires exactly once.
    send_tick(1'b1, 12'd20, 1'b0, 32'd10000, 1'b0, 1'b0);
    send_tick(1'b1, 12'd20, 1'b0, 32'd11999, 1'b0, 1'b0);
    send_tick(1'b1, 12'd20, 1'b0, 32'd12000, 1'b0, 1'b0);
    send_tick(1'b1, 12'd20, 1'b0, 32'd20000, 1'b0, 1'b0);
    send_tick(1'b0, 12'd20, 1'b0, 32'd20001, 1'b0, 1'b0);
    // Modal block cancels both hold latches, across the time wrap.
    send_tick(1'b1, 12'd5, 1'b1, 32'hFFFF_FF00, 1'b0, 1'b1);
    send_tick(1'b1, 12'd5, 1'b1, 32'h0000_1000, 1'b0, 1'b0);
    send_tick(1'b0, 12'd5, 1'b0, 32'h0000_1100, 1'b0, 1'b0);
    // Double tap completed just before the wrap, then a rise outside the band.
    send_tick(1'b1, 12'd0, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0);
    send_tick(1'b0, 12'd4095, 1'b0, 32'h0000_0010, 1'b0, 1'b0);
    send_tick(1'b1, 12'd4095, 1'b0, 32'h0000_0020, 1'b0, 1'b0);
    send_tick(1'b0, 12'd4095, 1'b0, 32'h0000_0030, 1'b0, 1'b0);
    // Asleep: a touch rise wakes, a held button is disarmed.
    send_tick(1'b0, 12'd0, 1'b1, 32'h0000_0100, 1'b1, 1'b0);
    send_tick(1'b1, 12'd0, 1'b1, 32'h0000_5000, 1'b1, 1'b0);
    send_tick(1'b1, 12'd0, 1'b1, 32'h0000_9000, 1'b0, 1'b0);
    send_tick(1'b0, 12'd0, 1'b0, 32'h0000_9100, 1'b0, 1'b0);

    // Register defaults, with a long hold-off on the result side.
    run_phase(12'd40, 16'd400, 16'd2000, 1'b1, 170, 1'b1);

    // Largest settings, no idling on either side.
    wait_idle();
    idle_on  = 1'b0;
    stall_on = 1'b0;
    run_phase(12'd4095, 16'hFFFF, 16'hFFFF, 1'b1, 150, 1'b0);
    wait_idle();
    idle_on  = 1'b1;
    stall_on = 1'b1;

    // A write to an index with no register behind it changes nothing.
    write_reg(CFG_UNUSED_IDX, 16'hFFFF);

    // Smallest settings, button source off.
    run_phase(12'd0, 16'd0, 16'd0, 1'b0, 120, 1'b0);

    // Disabled for a while: state must hold across it.
    wait_idle();
    write_reg(CFG_ENABLED, 16'd0);
    repeat (4) play_sequence();
    wait_idle();
    write_reg(CFG_ENABLED, 16'd1);

    // Random settings, then tiny ones.
    run_phase(HeaderBits'($urandom_range(4095, 0)), WindowBits'($urandom_range(1000, 0)),
              WindowBits'($urandom_range(3000, 0)), 1'b1, 130, 1'b0);
    run_phase(12'd1, 16'd1, 16'd1, 1'b1, 130, 1'b1);

    wait_idle();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/thgd_pkg.sv
rtl/thgd_touch.sv
rtl/thgd_button.sv
rtl/tap_hold_gesture_detector.sv
tb/thgd_gesture_checker.sv
tb/testbench.sv
